[sv/assert_macros.svh]
// Assertion shorthands used by the mixer RTL.
// Each one samples on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/psvm_pkg.sv]
package psvm_pkg;

  // Bank size and phase format
  localparam int VOICES          = 36;
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int VOICE_W   = 6;
  localparam int STEP_W    = 23;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 6;
  localparam int VOL_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [VOL_W-1:0] VOLUME_RESET = VOL_W'(6554);

  // Internal widths
  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WALK_W    = $clog2(VOICES + 1);
  localparam int ADD_W     = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int WORD_W    = PHASE_BITS + STEP_W;
  localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
  localparam int QIDX_W    = SINE_TABLE_BITS - 1;
  localparam int MAG_W     = SAMPLE_W - 1;
  localparam int SUM_W     = SAMPLE_W + $clog2(VOICES + 1);
  localparam int RECIP_W   = 17;
  localparam int MUL_A_W   = SUM_W + RECIP_W + 1;
  localparam int MUL_B_W   = ((RECIP_W > VOL_W) ? RECIP_W : VOL_W) + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  // recip is Q16 and volume Q16
  localparam int OUT_SHIFT = 32;
  localparam int SHIFT_W   = PROD_W - OUT_SHIFT;

  typedef longint unsigned u64_t;

  // Input kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK,
    KIND_NOTE_ON,
    KIND_NOTE_OFF,
    KIND_ALL_OFF
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME,
    REG_SUSTAIN
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  // Taylor coefficients of sin(pi/2 x), Q30
  localparam u64_t K1 = 64'd1686629713;
  localparam u64_t K3 = 64'd693598668;
  localparam u64_t K5 = 64'd85569299;
  localparam u64_t K7 = 64'd5026995;
  localparam u64_t K9 = 64'd172272;

  typedef logic [MAG_W-1:0]   sine_tab_t  [QUARTER + 1];
  typedef logic [RECIP_W-1:0] recip_tab_t [VOICES + 1];

  // Quarter-wave table, worked out at elaboration
  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    u64_t      x;
    u64_t      x2;
    u64_t      p;
    u64_t      q;
    for (int i = 0; i <= QUARTER; i++) begin
      x  = u64_t'(i) << (30 - (SINE_TABLE_BITS - 2));
      x2 = (x * x) >> 30;
      p  = K9;
      p  = K7 - ((p * x2) >> 30);
      p  = K5 - ((p * x2) >> 30);
      p  = K3 - ((p * x2) >> 30);
      p  = K1 - ((p * x2) >> 30);
      q  = (((p * x) >> 30) + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      t[i] = MAG_W'(q);
    end
    return t;
  endfunction

  // floor(65536 / sqrt(n)) by binary search, zero for n = 0
  function automatic recip_tab_t build_recip();
    recip_tab_t t;
    u64_t       lo;
    u64_t       hi;
    u64_t       mid;
    t[0] = '0;
    for (int n = 1; n <= VOICES; n++) begin
      lo = 64'd0;
      hi = 64'd65536;
      for (int s = 0; s < 20; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (mid * mid * u64_t'(n) <= (u64_t'(1) << 32)) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      t[n] = RECIP_W'(lo);
    end
    return t;
  endfunction

  localparam sine_tab_t  SINE_Q  = build_sine();
  localparam recip_tab_t RECIP_Q = build_recip();

  // Signed sine of a phase: top bits pick quadrant and quarter-table entry
  function automatic logic signed [SAMPLE_W-1:0] sine_of(input logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QIDX_W-2:0]          j;
    logic [QIDX_W-1:0]          tidx;
    logic [MAG_W-1:0]           mag;
    idx  = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    j    = idx[SINE_TABLE_BITS-3:0];
    tidx = quad[0] ? (QIDX_W'(QUARTER) - {1'b0, j}) : {1'b0, j};
    mag  = SINE_Q[tidx];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

[sv/polyphonic_sine_voice_mixer.sv]
// Note on, note off and all off do not stall the input; the next word may be taken the cycle after.
// A tick walks the voice RAM one voice a cycle through a read, phase-add, sine and
// accumulate pipeline, then runs two passes of one shared multiplier and loads the sample
// word once the output register is free; the next word is taken after that, back in idle.
// Reset: all voices inactive, count zero, volume 6554, sustain off, output empty.
// The voice RAM is not cleared; an inactive voice's entry is ignored by the walk and rewritten by note on.
`include "assert_macros.svh"

module polyphonic_sine_voice_mixer import psvm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [VOICE_W-1:0]         voice,
  input  logic [STEP_W-1:0]          phase_step,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [COUNT_W-1:0]         active_count,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  state_t state;
  state_t state_next;

  logic [VOICES-1:0]  voice_active;
  logic [COUNT_W-1:0] active_total;
  logic [VOL_W-1:0]   volume;
  logic               sustain;

  // Walk pipeline
  logic [WALK_W-1:0]          rd_idx;
  logic                       p1_vld;
  logic [VIDX_W-1:0]          p1_idx;
  logic                       p2_vld;
  logic [PHASE_BITS-1:0]      ph2;
  logic                       p3_vld;
  logic signed [SAMPLE_W-1:0] sin3;
  logic signed [SUM_W-1:0]    sum;
  logic signed [PROD_W-1:0]   prod;

  // Control
  logic walk_issue;
  logic walk_done;
  logic out_load;
  logic in_accept;
  kind_t in_kind;
  logic voice_ok;
  logic [VIDX_W-1:0] vidx;

  // RAM ports
  logic                  ram_we;
  logic [VIDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     ram_rdata;
  logic [PHASE_BITS-1:0] rd_phase;
  logic [STEP_W-1:0]     rd_step;
  logic [PHASE_BITS-1:0] new_phase;
  logic                  p1_act;

  // Multiplier and output rounding
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   biased;
  logic signed [SHIFT_W-1:0]  shifted;
  logic signed [SAMPLE_W-1:0] sat;

  assign in_kind   = kind_t'(kind);
  assign in_accept = in_valid && !in_stall;
  assign voice_ok  = ({1'b0, voice} < (VOICE_W + 1)'(VOICES));
  assign vidx      = voice[VIDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_TICK) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall   = (state != ST_IDLE);
    walk_issue = (state == ST_WALK) && (rd_idx < WALK_W'(VOICES));
    walk_done  = (state == ST_WALK) && (rd_idx == WALK_W'(VOICES)) &&
                 !p1_vld && !p2_vld && !p3_vld;
    out_load   = (state == ST_DONE) && (!out_valid || !out_stall);
    if (state == ST_MUL1) begin
      mul_a = MUL_A_W'(sum);
      mul_b = $signed({1'b0, RECIP_Q[active_total]});
    end else begin
      mul_a = prod[MUL_A_W-1:0];
      mul_b = $signed({1'b0, volume});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Voice RAM: phase and step of every voice in one word
  assign rd_phase  = ram_rdata[WORD_W-1 -: PHASE_BITS];
  assign rd_step   = ram_rdata[STEP_W-1:0];
  assign new_phase = PHASE_BITS'(ADD_W'(rd_phase) + ADD_W'(rd_step));
  assign p1_act    = voice_active[p1_idx];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = vidx;
    ram_wdata = '0;
    if (p1_vld) begin
      ram_we    = p1_act;
      ram_waddr = p1_idx;
      ram_wdata = {new_phase, rd_step};
    end else if (in_accept && voice_ok) begin
      if (in_kind == KIND_NOTE_ON) begin
        ram_we    = 1'b1;
        ram_wdata = {PHASE_BITS'(0), phase_step};
      end else if (in_kind == KIND_NOTE_OFF && !sustain) begin
        ram_we = 1'b1;
      end
    end
  end

  psvm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[VIDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume  <= VOLUME_RESET;
      sustain <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VOLUME:  volume  <= cfg_data[VOL_W-1:0];
        REG_SUSTAIN: sustain <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Voice activity and count
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active <= '0;
      active_total <= '0;
    end else if (in_accept) begin
      unique case (in_kind)
        KIND_NOTE_ON: begin
          if (voice_ok) begin
            voice_active[vidx] <= 1'b1;
            if (!voice_active[vidx]) begin
              active_total <= active_total + COUNT_W'(1);
            end
          end
        end
        KIND_NOTE_OFF: begin
          if (voice_ok && !sustain) begin
            voice_active[vidx] <= 1'b0;
            if (voice_active[vidx]) begin
              active_total <= active_total - COUNT_W'(1);
            end
          end
        end
        KIND_ALL_OFF: begin
          voice_active <= '0;
          active_total <= '0;
        end
        KIND_TICK: ;
        default: ;
      endcase
    end
  end

  // Walk pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      if (in_accept && in_kind == KIND_TICK) begin
        rd_idx <= '0;
      end else if (walk_issue) begin
        rd_idx <= rd_idx + WALK_W'(1);
      end
      p1_vld <= walk_issue;
      p2_vld <= p1_vld && p1_act;
      p3_vld <= p2_vld;
    end
  end

  // Walk pipeline data: phase, sine, sum; multiplier product
  always_ff @(posedge clk) begin
    p1_idx <= rd_idx[VIDX_W-1:0];
    ph2    <= new_phase;
    sin3   <= sine_of(ph2);
    if (in_accept && in_kind == KIND_TICK) begin
      sum <= '0;
    end else if (p3_vld) begin
      sum <= sum + SUM_W'(sin3);
    end
    if (state == ST_MUL1 || state == ST_MUL2) begin
      prod <= mul_p;
    end
  end

  // Shared multiplier: sum * recip, then * volume
  assign mul_p = mul_a * mul_b;

  // Round half up at bit 32 and saturate
  assign biased  = prod + (PROD_W'(1) <<< (OUT_SHIFT - 1));
  assign shifted = SHIFT_W'(biased >>> OUT_SHIFT);

  always_comb begin
    if (shifted > SHIFT_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (shifted < -SHIFT_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample       <= sat;
      active_count <= active_total;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_count_matches, active_total == COUNT_W'($countones(voice_active)), "active count out of step with voice flags")
  `ASSERT_IMPLIES(a_walk_bound, state == ST_WALK, rd_idx <= WALK_W'(VOICES), "walk index past last voice")
  `ASSERT_NEXT(a_voices_frozen, state != ST_IDLE, $stable(voice_active), "voice flags changed during a tick")
  `ASSERT_IMPLIES(a_out_from_done, $rose(out_valid), $past(state == ST_DONE), "output word raised outside completion")

endmodule

[sv/psvm_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data
module psvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/polyphonic_sine_voice_mixer_test.sv]
`timescale 1ns / 100ps

module polyphonic_sine_voice_mixer_test;
  import psvm_pkg::*;

  // One mixed sample as the block should present it
  typedef struct {
    logic signed [SAMPLE_W-1:0] level;
    logic [COUNT_W-1:0]         voices;
  } mix_t;

  // Voice bank model plus the samples still owed by the block
  class mix_scoreboard;
    logic [PHASE_BITS-1:0] acc [VOICES];
    logic [STEP_W-1:0]     inc [VOICES];
    bit                    sounding [VOICES];
    int unsigned           sounding_n;
    logic [VOL_W-1:0]      gain;
    bit                    held;
    int unsigned           quarter_wave [QUARTER + 1];
    longint                inv_root [VOICES + 1];
    mix_t                  owed [$];
    int                    errors;

    function new();
      longint unsigned x, x2, p, q, lo, hi, mid;
      // quarter-wave sine, odd Taylor series in Q30, rounded to Q15
      for (int i = 0; i <= QUARTER; i++) begin
        x  = 64'(i) << (30 - (SINE_TABLE_BITS - 2));
        x2 = (x * x) >> 30;
        p  = K9;
        p  = K7 - ((p * x2) >> 30);
        p  = K5 - ((p * x2) >> 30);
        p  = K3 - ((p * x2) >> 30);
        p  = K1 - ((p * x2) >> 30);
        q  = (((p * x) >> 30) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
          q = 64'd32767;
        end
        quarter_wave[i] = int'(q);
      end
      // floor(65536 / sqrt(n))
      inv_root[0] = 0;
      for (int n = 1; n <= VOICES; n++) begin
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (mid * mid * 64'(n) <= (64'd1 << 32)) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        inv_root[n] = longint'(lo);
      end
      errors = 0;
      gain   = VOLUME_RESET;
      held   = 1'b0;
      clear_bank();
    endfunction

    function void clear_bank();
      for (int k = 0; k < VOICES; k++) begin
        acc[k]      = '0;
        inc[k]      = '0;
        sounding[k] = 1'b0;
      end
      sounding_n = 0;
    endfunction

    // top bits of the phase pick quadrant and mirrored table entry
    function int sine_at(logic [PHASE_BITS-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [1:0]                 quad;
      int unsigned                j;
      int                         mag;
      idx  = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      j    = idx[SINE_TABLE_BITS-3:0];
      mag  = quad[0] ? quarter_wave[QUARTER - j] : quarter_wave[j];
      return quad[1] ? -mag : mag;
    endfunction

    // advance every sounding voice, mix, normalise, scale, saturate
    function mix_t next_sample();
      longint      sum;
      longint      total;
      int unsigned n;
      mix_t        m;
      sum = 0;
      n   = 0;
      for (int k = 0; k < VOICES; k++) begin
        if (sounding[k]) begin
          acc[k] = acc[k] + PHASE_BITS'(inc[k]);
          sum += sine_at(acc[k]);
          n++;
        end
      end
      total = sum * inv_root[n] * longint'(gain);
      total = (total + (longint'(1) << 31)) >>> 32;
      if (total > 32767) begin
        total = 32767;
      end else if (total < -32768) begin
        total = -32768;
      end
      m.level  = SAMPLE_W'(total);
      m.voices = COUNT_W'(n);
      return m;
    endfunction

    // a word taken by the block
    function void note_word(kind_t k, logic [VOICE_W-1:0] v, logic [STEP_W-1:0] s);
      case (k)
        KIND_NOTE_ON: begin
          if (v < VOICES) begin
            acc[v] = '0;
            inc[v] = s;
            if (!sounding[v]) begin
              sounding[v] = 1'b1;
              sounding_n++;
            end
          end
        end
        KIND_NOTE_OFF: begin
          if (v < VOICES && !held) begin
            if (sounding[v]) begin
              sounding[v] = 1'b0;
              sounding_n--;
            end
            acc[v] = '0;
            inc[v] = '0;
          end
        end
        KIND_ALL_OFF: begin
          clear_bank();
        end
        default: begin
          owed = {owed, next_sample()};
        end
      endcase
    endfunction

    // a sample taken from the block
    function void check_sample(logic signed [SAMPLE_W-1:0] got, logic [COUNT_W-1:0] got_n);
      mix_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: sample %0d, count %0d with nothing expected", $time, got, got_n);
        return;
      end
      want = owed.pop_front();
      if (got !== want.level) begin
        errors++;
        $display("%0t: sample expected %0d, got %0d", $time, want.level, got);
      end
      if (got_n !== want.voices) begin
        errors++;
        $display("%0t: active_count expected %0d, got %0d", $time, want.voices, got_n);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [KIND_W-1:0]          kind;
  logic [VOICE_W-1:0]         voice;
  logic [STEP_W-1:0]          phase_step;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COUNT_W-1:0]         active_count;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  mix_scoreboard bank_model = new();
  bit            calm_in;
  bit            calm_out;
  int            words_sent;
  int            stall_left;

  polyphonic_sine_voice_mixer dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // words taken by the block drive the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      bank_model.note_word(kind_t'(kind), voice, phase_step);
    end
  end

  // output side: check each sample taken, then draw the stall for the next one
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      bank_model.check_sample(sample, active_count);
      if ($urandom_range(0, 15) == 0) begin
        calm_out = !calm_out;
      end
      stall_left = calm_out ? 0 : $urandom_range(0, 9);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // present one word after a random gap and hold it until taken
  task automatic send_word(kind_t k, logic [VOICE_W-1:0] v, logic [STEP_W-1:0] s);
    int gap;
    if ($urandom_range(0, 31) == 0) begin
      calm_in = !calm_in;
    end
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    voice      <= v;
    phase_step <= s;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // wait for every owed sample, then let a trailing note word finish
  task automatic drain(int settle_cycles);
    in_valid <= 1'b0;
    while (bank_model.owed.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  // both registers, only while the block is idle
  task automatic set_controls(logic [VOL_W-1:0] vol, bit hold);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VOLUME;
    cfg_data  <= CFG_W'(vol);
    @(posedge clk);
    cfg_index <= REG_SUSTAIN;
    cfg_data  <= CFG_W'(hold);
    @(posedge clk);
    cfg_we <= 1'b0;
    bank_model.gain = vol;
    bank_model.held = hold;
  endtask

  // mostly real voices, now and then an index past the bank
  function automatic logic [VOICE_W-1:0] pick_voice();
    if ($urandom_range(0, 9) == 0) begin
      return VOICE_W'($urandom_range(VOICES, (1 << VOICE_W) - 1));
    end
    return VOICE_W'($urandom_range(0, VOICES - 1));
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return STEP_W'($urandom_range(0, 4095));
      3: return STEP_W'($urandom_range(0, 7) << 20);
      default: return STEP_W'($urandom);
    endcase
  endfunction

  // random traffic; chords start a run of voices on one step, then tick
  task automatic random_run(int count);
    int               stop;
    int               pick;
    int               width;
    int               base;
    logic [STEP_W-1:0] s;
    stop = words_sent + count;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 52) begin
        send_word(KIND_TICK, VOICE_W'($urandom), STEP_W'($urandom));
      end else if (pick < 78) begin
        send_word(KIND_NOTE_ON, pick_voice(), pick_step());
      end else if (pick < 95) begin
        send_word(KIND_NOTE_OFF, pick_voice(), STEP_W'($urandom));
      end else if (pick < 98) begin
        send_word(KIND_ALL_OFF, VOICE_W'($urandom), STEP_W'($urandom));
      end else begin
        width = $urandom_range(2, VOICES);
        base  = $urandom_range(0, VOICES - 1);
        s     = pick_step();
        for (int i = 0; i < width; i++) begin
          send_word(KIND_NOTE_ON, VOICE_W'((base + i) % VOICES), s);
        end
        repeat ($urandom_range(1, 6)) send_word(KIND_TICK, '0, '0);
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_TICK;
    voice      <= '0;
    phase_step <= '0;
    out_stall  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_VOLUME;
    cfg_data   <= '0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full gain: empty bank, field extremes, ignored indexes, restart, clears
    set_controls(VOL_W'(65536), 1'b0);
    send_word(KIND_TICK, '1, '1);
    send_word(KIND_NOTE_ON, '0, '1);
    send_word(KIND_NOTE_ON, VOICE_W'(VOICES - 1), '0);
    send_word(KIND_NOTE_ON, VOICE_W'(VOICES), STEP_W'(123));
    send_word(KIND_NOTE_ON, '1, '1);
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_NOTE_ON, '0, STEP_W'(24'h400000));
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_NOTE_OFF, VOICE_W'(20), '0);
    send_word(KIND_NOTE_OFF, '1, '0);
    send_word(KIND_NOTE_OFF, VOICE_W'(VOICES - 1), '1);
    send_word(KIND_TICK, '0, '0);
    send_word(KIND_ALL_OFF, '0, '0);
    send_word(KIND_TICK, '0, '0);
    // two voices on quarter-cycle steps: saturate high, zero, saturate low
    send_word(KIND_NOTE_ON, VOICE_W'(1), STEP_W'(24'h400000));
    send_word(KIND_NOTE_ON, VOICE_W'(2), STEP_W'(24'h400000));
    repeat (3) send_word(KIND_TICK, '0, '0);
    drain(60);

    // silent gain with sustain: note off has no effect
    set_controls('0, 1'b1);
    send_word(KIND_NOTE_ON, VOICE_W'(7), STEP_W'(23'h123456));
    send_word(KIND_NOTE_OFF, VOICE_W'(7), '0);
    send_word(KIND_TICK, '0, '0);
    drain(60);

    // random phases over a spread of settings
    set_controls(VOLUME_RESET, 1'b0);
    random_run(300);
    drain(60);
    set_controls(VOL_W'(65536), 1'b1);
    random_run(300);
    drain(60);
    set_controls('0, 1'b0);
    random_run(300);
    drain(60);
    set_controls(VOL_W'($urandom_range(0, 65536)), 1'($urandom));
    random_run(300);
    drain(60);
    set_controls(VOL_W'(32768), 1'b1);
    random_run(300);
    drain(60);
    set_controls(VOL_W'($urandom_range(0, 65536)), 1'b0);
    random_run(300);
    drain(60);

    if (bank_model.errors == 0 && bank_model.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
